[rtl/lrng_pkg.sv]
// ----------------------------------------------------------------------------
// lrng_pkg
// Constants shared by the Lehmer generator and its shared add/subtract unit.
// ----------------------------------------------------------------------------
`default_nettype none

package lrng_pkg;

    localparam int LRNG_ALU_W = 32;

    localparam logic [30:0] LRNG_MOD = 31'd2147483647;
    localparam logic [14:0] LRNG_MUL = 15'd16807;
    localparam logic [30:0] LRNG_DIV = 31'd2147483646;

    localparam int LRNG_MUL_STEPS = 33;
    localparam int LRNG_DIV_STEPS = 32;
    localparam int LRNG_CNT_W     = 6;

    typedef struct packed {
        logic [LRNG_ALU_W-1:0] a;
        logic [LRNG_ALU_W-1:0] b;
        logic                  sub;
    } t_alu_req;

endpackage

`default_nettype wire

[rtl/lrng_alu.sv]
// ----------------------------------------------------------------------------
// lrng_alu
// Shared add/subtract unit: a + b, or a - b with carry out as no-borrow flag.
// ----------------------------------------------------------------------------
`default_nettype none

module lrng_alu (
    input  var lrng_pkg::t_alu_req          i_req,
    output logic [lrng_pkg::LRNG_ALU_W:0]   o_sum
);
    import lrng_pkg::*;

    logic [LRNG_ALU_W-1:0] b_eff;

    assign b_eff = i_req.sub ? ~i_req.b : i_req.b;
    assign o_sum = {1'b0, i_req.a} + {1'b0, b_eff} + (LRNG_ALU_W+1)'(i_req.sub);

endmodule

`default_nettype wire

[rtl/lehmer_rng_with_range_mapping.sv]
// ----------------------------------------------------------------------------
// lehmer_rng_with_range_mapping
// Park-Miller minimal standard generator (x*16807 mod 2^31-1) with exact
// integer mapping of each draw onto range_low..range_high.
// ----------------------------------------------------------------------------
//  channel  | dir | tdata (low bit up)                         | tuser
//  s_axis   | in  | seed_value[31:0] range_low[63:32]          | func
//           |     | range_high[95:64]                          |
//  m_axis   | out | raw_value[30:0] ranged_value[62:31] pad[63] | range_error
//
//  Reseed: IDLE, DONE. Draw with bad range: IDLE, FOLD, DONE. Draw: IDLE,
//  FOLD, MUL, DIV, ADD, DONE, with a 33-step shift-add multiply and a
//  32-step restoring divide that share one 32-bit add/subtract unit.
//  Synchronous active-low reset; generator state resets to 1.
//  One item in flight; a finished item waits in the output register while
//  the next item is taken in.
// ----------------------------------------------------------------------------
`default_nettype none

module lehmer_rng_with_range_mapping (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_s_axis_tvalid,
    output logic        o_s_axis_tready,
    input  logic [95:0] i_s_axis_tdata,   // seed_value, range_low, range_high
    input  logic        i_s_axis_tuser,   // func
    output logic        o_m_axis_tvalid,
    input  logic        i_m_axis_tready,
    output logic [63:0] o_m_axis_tdata,   // raw_value, ranged_value, zero pad
    output logic        o_m_axis_tuser    // range_error
);
    import lrng_pkg::*;

    typedef enum logic [2:0] {
        S_IDLE,
        S_FOLD,
        S_MUL,
        S_DIV,
        S_ADD,
        S_DONE
    } t_state;

    t_state                r_state;
    logic [30:0]           r_gen;
    logic [45:0]           r_prod;
    logic [31:0]           r_lo;
    logic [31:0]           r_hi;
    logic [63:0]           r_p;
    logic [30:0]           r_mcand;
    logic [LRNG_CNT_W-1:0] r_cnt;
    logic [31:0]           r_ranged;
    logic                  r_err;
    logic                  r_ovalid;
    logic [63:0]           r_odata;
    logic                  r_ouser;

    t_alu_req              alu_req;
    logic [LRNG_ALU_W:0]   alu_sum;

    logic [30:0]           n_gen_src;
    logic [45:0]           n_prod;
    logic [31:0]           n_fold_sum;
    logic [30:0]           n_fold;
    logic [31:0]           n_seed_sum;
    logic [30:0]           n_seed_red;
    logic [30:0]           n_seed;
    logic [32:0]           n_diff;
    logic [32:0]           n_span;
    logic [31:0]           n_upper;
    logic [30:0]           n_rem;
    logic                  in_acc;
    logic                  out_free;

    lrng_alu u_alu (
        .i_req (alu_req),
        .o_sum (alu_sum)
    );

    assign o_s_axis_tready = (r_state == S_IDLE);
    assign in_acc          = i_s_axis_tvalid && o_s_axis_tready;
    assign out_free        = !r_ovalid || i_m_axis_tready;

    assign o_m_axis_tvalid = r_ovalid;
    assign o_m_axis_tdata  = r_odata;
    assign o_m_axis_tuser  = r_ouser;

    assign n_gen_src  = (r_gen == 31'd0) ? 31'd1 : r_gen;
    assign n_prod     = n_gen_src * LRNG_MUL;

    assign n_fold_sum = {1'b0, r_prod[30:0]} + {17'd0, r_prod[45:31]};
    assign n_fold     = (n_fold_sum >= {1'b0, LRNG_MOD}) ?
                        31'(n_fold_sum - {1'b0, LRNG_MOD}) : n_fold_sum[30:0];

    assign n_seed_sum = {1'b0, i_s_axis_tdata[30:0]} + {31'd0, i_s_axis_tdata[31]};
    assign n_seed_red = (n_seed_sum >= {1'b0, LRNG_MOD}) ?
                        31'(n_seed_sum - {1'b0, LRNG_MOD}) : n_seed_sum[30:0];
    assign n_seed     = (n_seed_red == 31'd0) ? 31'd1 : n_seed_red;

    assign n_diff = {r_hi[31], r_hi} - {r_lo[31], r_lo};
    assign n_span = {1'b0, n_diff[31:0]} + 33'd1;

    always_comb begin
        alu_req.a   = r_lo;
        alu_req.b   = r_p[31:0];
        alu_req.sub = 1'b0;
        unique case (r_state)
            S_MUL: begin
                alu_req.a   = {1'b0, r_p[63:33]};
                alu_req.b   = {1'b0, r_mcand};
                alu_req.sub = 1'b0;
            end
            S_DIV: begin
                alu_req.a   = {r_p[62:32], r_p[31]};
                alu_req.b   = {1'b0, LRNG_DIV};
                alu_req.sub = 1'b1;
            end
            default: begin
                alu_req.a   = r_lo;
                alu_req.b   = r_p[31:0];
                alu_req.sub = 1'b0;
            end
        endcase
    end

    assign n_upper = r_p[0] ? alu_sum[31:0] : {1'b0, r_p[63:33]};
    assign n_rem   = alu_sum[32] ? alu_sum[30:0] : alu_req.a[30:0];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_IDLE;
            r_gen    <= 31'd1;
            r_ovalid <= 1'b0;
        end else begin
            if (r_state == S_DONE && out_free) begin
                r_ovalid <= 1'b1;
            end else if (i_m_axis_tready) begin
                r_ovalid <= 1'b0;
            end
            unique case (r_state)
                S_IDLE: begin
                    r_prod <= n_prod;
                    if (in_acc) begin
                        r_lo <= i_s_axis_tdata[63:32];
                        r_hi <= i_s_axis_tdata[95:64];
                        if (i_s_axis_tuser) begin
                            r_state <= S_FOLD;
                        end else begin
                            r_gen    <= n_seed;
                            r_ranged <= i_s_axis_tdata[63:32];
                            r_err    <= 1'b0;
                            r_state  <= S_DONE;
                        end
                    end
                end
                S_FOLD: begin
                    r_gen <= n_fold;
                    if (n_diff[32]) begin
                        r_ranged <= r_lo;
                        r_err    <= 1'b1;
                        r_state  <= S_DONE;
                    end else begin
                        r_err   <= 1'b0;
                        r_p     <= {31'd0, n_span};
                        r_mcand <= n_fold - 31'd1;
                        r_cnt   <= '0;
                        r_state <= S_MUL;
                    end
                end
                S_MUL: begin
                    r_p <= {n_upper, r_p[32:1]};
                    if (r_cnt == LRNG_CNT_W'(LRNG_MUL_STEPS - 1)) begin
                        r_cnt   <= '0;
                        r_state <= S_DIV;
                    end else begin
                        r_cnt <= r_cnt + LRNG_CNT_W'(1);
                    end
                end
                S_DIV: begin
                    r_p <= {1'b0, n_rem, r_p[30:0], alu_sum[32]};
                    if (r_cnt == LRNG_CNT_W'(LRNG_DIV_STEPS - 1)) begin
                        r_state <= S_ADD;
                    end else begin
                        r_cnt <= r_cnt + LRNG_CNT_W'(1);
                    end
                end
                S_ADD: begin
                    r_ranged <= alu_sum[31:0];
                    r_state  <= S_DONE;
                end
                S_DONE: begin
                    if (out_free) begin
                        r_odata  <= {1'b0, r_ranged, r_gen};
                        r_ouser  <= r_err;
                        r_state  <= S_IDLE;
                    end
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

endmodule

`default_nettype wire
